/* rtl/rprp_pkg.sv */
`timescale 1ns / 1ps
package rprp_pkg;

    localparam int ANGLE_STAGES = 16;
    localparam int TABLE_LEN = 24;
    localparam int NSTG = (ANGLE_STAGES < TABLE_LEN) ? ANGLE_STAGES : TABLE_LEN;
    localparam logic [29:0] INV_GAIN = 30'd652032874;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    localparam int VW = 33;
    localparam int RW = 31;

    localparam logic [7:0] MAX_RADIUS_RST = 8'd64;
    localparam logic [12:0] Z_BAND_RST = 13'd128;

    typedef enum logic [0:0] {
        REG_MAX_RADIUS = 1'b0,
        REG_Z_BAND = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MARK_LEVEL = 2'd0,
        MARK_ABOVE = 2'd1,
        MARK_BELOW = 2'd2
    } marker_t;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] tab [0:23];
        tab[0] = 32'd536870912; tab[1] = 32'd316933406; tab[2] = 32'd167458907;
        tab[3] = 32'd85004756; tab[4] = 32'd42667331; tab[5] = 32'd21354465;
        tab[6] = 32'd10679838; tab[7] = 32'd5340245; tab[8] = 32'd2670163;
        tab[9] = 32'd1335087; tab[10] = 32'd667544; tab[11] = 32'd333772;
        tab[12] = 32'd166886; tab[13] = 32'd83443; tab[14] = 32'd41722;
        tab[15] = 32'd20861; tab[16] = 32'd10430; tab[17] = 32'd5215;
        tab[18] = 32'd2608; tab[19] = 32'd1304; tab[20] = 32'd652;
        tab[21] = 32'd326; tab[22] = 32'd163; tab[23] = 32'd81;
        return tab[i];
    endfunction

endpackage

/* rtl/relative_position_to_radar_plot.sv */
`timescale 1ns / 1ps
// Radar plot position of an object relative to a viewer.
// Input channel: in_valid / in_stall with viewer and object positions
// (17-bit signed, 3 fraction bits) and the 16-bit binary-angle yaw.
// Output channel: out_valid / out_stall with plot_x, plot_y and marker_kind.
// Configuration: cfg_valid / cfg_ready with cfg_index (0 max_radius,
// 1 z_band) and cfg_data; cfg_ready is always high.
// The datapath is a pipeline: one difference stage, one vectoring CORDIC
// stage per angle step, two gain/clamp stages, one quadrant stage, one
// rotation CORDIC stage per angle step, two output gain stages and the
// output register. One item is accepted every cycle while out_stall is
// low; the whole pipeline moves as one shift chain gated by out_stall,
// so throughput is one item per cycle when the receiver does not stall.
// in_stall is out_stall: while the receiver stalls, every stage holds
// and no beat is lost or repeated.
// Reset clears all valid bits and loads max_radius 64 and z_band 128.
module relative_position_to_radar_plot (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [16:0] viewer_x,
    input  logic signed [16:0] viewer_y,
    input  logic signed [16:0] viewer_z,
    input  logic signed [16:0] object_x,
    input  logic signed [16:0] object_y,
    input  logic signed [16:0] object_z,
    input  logic        [15:0] view_yaw,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [8:0]  plot_x,
    output logic signed [8:0]  plot_y,
    output logic        [1:0]  marker_kind,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [0:0]  cfg_index,
    input  logic        [12:0] cfg_data
);

    localparam int N = rprp_pkg::NSTG;
    localparam int VW = rprp_pkg::VW;
    localparam int RW = rprp_pkg::RW;

    logic        adv;
    logic [7:0]  max_radius_reg;
    logic [12:0] z_band_reg;

    assign adv = !out_stall;
    assign in_stall = out_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_radius_reg <= rprp_pkg::MAX_RADIUS_RST;
            z_band_reg <= rprp_pkg::Z_BAND_RST;
        end
        else if (cfg_valid)
        begin
            unique case (rprp_pkg::cfg_reg_t'(cfg_index))
                rprp_pkg::REG_MAX_RADIUS: max_radius_reg <= cfg_data[7:0];
                rprp_pkg::REG_Z_BAND:     z_band_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: differences and marker
    logic                 s0_v_reg;
    logic signed [VW-1:0] s0_x_reg, s0_y_reg;
    logic [31:0]          s0_z_reg;
    logic [15:0]          s0_yaw_reg;
    logic [1:0]           s0_mk_reg;
    logic signed [17:0]   dx, dy, dz, tpos;
    logic [1:0]           mk_next;

    always_comb
    begin
        dx = 18'(object_x) - 18'(viewer_x);
        dy = 18'(object_y) - 18'(viewer_y);
        dz = 18'(viewer_z) - 18'(object_z);
        tpos = $signed({2'b00, z_band_reg, 3'b000});
        if (dz > -tpos && dz < tpos)
            mk_next = rprp_pkg::MARK_LEVEL;
        else if (dz <= -tpos)
            mk_next = rprp_pkg::MARK_ABOVE;
        else
            mk_next = rprp_pkg::MARK_BELOW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (adv)
            s0_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (dx < 0)
            begin
                s0_x_reg <= VW'(-dx) <<< 12;
                s0_y_reg <= VW'(-dy) <<< 12;
                s0_z_reg <= rprp_pkg::HALF_TURN;
            end
            else
            begin
                s0_x_reg <= VW'(dx) <<< 12;
                s0_y_reg <= VW'(dy) <<< 12;
                s0_z_reg <= '0;
            end
            s0_yaw_reg <= view_yaw;
            s0_mk_reg <= mk_next;
        end
    end

    // vectoring stages
    logic                 vv_reg [0:N];
    logic signed [VW-1:0] vx_reg [0:N];
    logic signed [VW-1:0] vy_reg [0:N];
    logic [31:0]          vz_reg [0:N];
    logic [15:0]          vyaw_reg [0:N];
    logic [1:0]           vmk_reg [0:N];

    always_comb
    begin
        vv_reg[0] = s0_v_reg;
        vx_reg[0] = s0_x_reg;
        vy_reg[0] = s0_y_reg;
        vz_reg[0] = s0_z_reg;
        vyaw_reg[0] = s0_yaw_reg;
        vmk_reg[0] = s0_mk_reg;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_vec
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vv_reg[i+1] <= 1'b0;
            else if (adv)
                vv_reg[i+1] <= vv_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!vy_reg[i][VW-1])
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + rprp_pkg::atan_entry(i);
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - rprp_pkg::atan_entry(i);
                end
                vyaw_reg[i+1] <= vyaw_reg[i];
                vmk_reg[i+1] <= vmk_reg[i];
            end
        end
    end

    // gain: split 32x30 into two 16-bit partial products
    logic        g1_v_reg, g2_v_reg, q_v_reg;
    logic [47:0] g1_lo_reg, g1_hi_reg;
    logic [31:0] g1_th_reg, g2_th_reg;
    logic [1:0]  g1_mk_reg, g2_mk_reg, q_mk_reg;
    logic [RW-1:0] g2_r_reg;
    logic [63:0] gprod;
    logic [63:0] rq_full;
    logic [31:0] cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_v_reg <= 1'b0;
            g2_v_reg <= 1'b0;
            q_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            g1_v_reg <= vv_reg[N];
            g2_v_reg <= g1_v_reg;
            q_v_reg <= g2_v_reg;
        end
    end

    always_comb
    begin
        gprod = {g1_hi_reg, 16'h0000} + {16'h0000, g1_lo_reg};
        rq_full = gprod >> 30;
        cap = {4'h0, max_radius_reg, 20'h00000};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_lo_reg <= 48'(vx_reg[N][15:0]) * 48'(rprp_pkg::INV_GAIN);
            g1_hi_reg <= 48'(vx_reg[N][31:16]) * 48'(rprp_pkg::INV_GAIN);
            g1_th_reg <= {vyaw_reg[N], 16'h0000} - vz_reg[N];
            g1_mk_reg <= vmk_reg[N];
            g2_r_reg <= (rq_full > 64'(cap)) ? RW'(cap) : RW'(rq_full);
            g2_th_reg <= g1_th_reg;
            g2_mk_reg <= g1_mk_reg;
        end
    end

    // quadrant fold
    logic signed [RW:0] q_x_reg;
    logic [31:0]        q_th_reg;
    logic [31:0]        th_q;

    assign th_q = g2_th_reg + rprp_pkg::QUARTER_TURN;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (th_q[31])
            begin
                q_x_reg <= -$signed({1'b0, g2_r_reg});
                q_th_reg <= g2_th_reg - rprp_pkg::HALF_TURN;
            end
            else
            begin
                q_x_reg <= $signed({1'b0, g2_r_reg});
                q_th_reg <= g2_th_reg;
            end
            q_mk_reg <= g2_mk_reg;
        end
    end

    // rotation stages
    localparam int XW = RW + 2;
    logic                 rv_reg [0:N];
    logic signed [XW-1:0] rx_reg [0:N];
    logic signed [XW-1:0] ry_reg [0:N];
    logic [31:0]          rth_reg [0:N];
    logic [1:0]           rmk_reg [0:N];

    always_comb
    begin
        rv_reg[0] = q_v_reg;
        rx_reg[0] = XW'(q_x_reg);
        ry_reg[0] = '0;
        rth_reg[0] = q_th_reg;
        rmk_reg[0] = q_mk_reg;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[i+1] <= 1'b0;
            else if (adv)
                rv_reg[i+1] <= rv_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!rth_reg[i][31])
                begin
                    rx_reg[i+1] <= rx_reg[i] - (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] + (rx_reg[i] >>> i);
                    rth_reg[i+1] <= rth_reg[i] - rprp_pkg::atan_entry(i);
                end
                else
                begin
                    rx_reg[i+1] <= rx_reg[i] + (ry_reg[i] >>> i);
                    ry_reg[i+1] <= ry_reg[i] - (rx_reg[i] >>> i);
                    rth_reg[i+1] <= rth_reg[i] + rprp_pkg::atan_entry(i);
                end
                rmk_reg[i+1] <= rmk_reg[i];
            end
        end
    end

    // output gain: magnitude times INV_GAIN, drop 50 bits, saturate
    logic        o1_v_reg, o2_v_reg, out_v_reg;
    logic [XW-1:0] mx, my;
    logic [47:0] o1_xl_reg, o1_xh_reg, o1_yl_reg, o1_yh_reg;
    logic        o1_xn_reg, o1_yn_reg, o2_xn_reg, o2_yn_reg;
    logic [1:0]  o1_mk_reg, o2_mk_reg;
    logic [7:0]  o2_xp_reg, o2_yp_reg;
    logic [63:0] px_full, py_full;
    logic [13:0] px_sh, py_sh;
    logic signed [8:0] plot_x_reg, plot_y_reg;
    logic [1:0]  mk_out_reg;

    always_comb
    begin
        mx = rx_reg[N][XW-1] ? XW'(-rx_reg[N]) : XW'(rx_reg[N]);
        my = ry_reg[N][XW-1] ? XW'(-ry_reg[N]) : XW'(ry_reg[N]);
        px_full = {o1_xh_reg, 16'h0000} + {16'h0000, o1_xl_reg};
        py_full = {o1_yh_reg, 16'h0000} + {16'h0000, o1_yl_reg};
        px_sh = px_full[63:50];
        py_sh = py_full[63:50];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o1_v_reg <= 1'b0;
            o2_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            o1_v_reg <= rv_reg[N];
            o2_v_reg <= o1_v_reg;
            out_v_reg <= o2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o1_xl_reg <= 48'(my[15:0]) * 48'(rprp_pkg::INV_GAIN);
            o1_xh_reg <= 48'(my[XW-1:16]) * 48'(rprp_pkg::INV_GAIN);
            o1_yl_reg <= 48'(mx[15:0]) * 48'(rprp_pkg::INV_GAIN);
            o1_yh_reg <= 48'(mx[XW-1:16]) * 48'(rprp_pkg::INV_GAIN);
            o1_xn_reg <= ry_reg[N][XW-1];
            o1_yn_reg <= rx_reg[N][XW-1];
            o1_mk_reg <= rmk_reg[N];
            o2_xp_reg <= (px_sh > 14'd255) ? 8'd255 : px_sh[7:0];
            o2_yp_reg <= (py_sh > 14'd255) ? 8'd255 : py_sh[7:0];
            o2_xn_reg <= o1_xn_reg;
            o2_yn_reg <= o1_yn_reg;
            o2_mk_reg <= o1_mk_reg;
            plot_x_reg <= o2_xn_reg ? -$signed({1'b0, o2_xp_reg})
                                    : $signed({1'b0, o2_xp_reg});
            plot_y_reg <= o2_yn_reg ? $signed({1'b0, o2_yp_reg})
                                    : -$signed({1'b0, o2_yp_reg});
            mk_out_reg <= o2_mk_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign plot_x = plot_x_reg;
    assign plot_y = plot_y_reg;
    assign marker_kind = mk_out_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_stall && out_valid |=> out_valid && $stable(plot_x) && $stable(plot_y))
        else $error("output beat not held under stall");
    a_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> marker_kind != 2'd3)
        else $error("bad marker code");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> plot_x != -9'sd256 && plot_y != -9'sd256)
        else $error("plot out of range");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_stall |=> $stable(o2_v_reg) && $stable(g2_v_reg))
        else $error("pipeline moved under stall");

endmodule
